[rtl/ppmp6_pkg.sv]
// ----------------------------------------------------------------------------
// ppmp6_pkg
// Shared types and constants for the PPM P6 stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppmp6_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_BAD_MAGIC   = 3'd0,
		ERR_BAD_NUMBER  = 3'd1,
		ERR_MAXVAL_ZERO = 3'd2,
		ERR_MAXVAL_BIG  = 3'd3,
		ERR_NO_WS       = 3'd4
	} err_t;

	localparam logic [7:0] CHAR_P    = 8'h50;
	localparam logic [7:0] CHAR_SIX  = 8'h36;
	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [7:0] CHAR_NL   = 8'h0A;
	localparam logic [7:0] CHAR_SP   = 8'h20;
	localparam logic [7:0] CHAR_TAB  = 8'h09;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam int unsigned MAXVAL_LIMIT = 255;
	localparam int unsigned NUM_LIMIT    = 65535;
	localparam int unsigned ACC_BITS     = 16;
	localparam int unsigned PROD_BITS    = 20;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	// classified input word as it crosses the queue
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
		logic       is_digit;
		logic       is_ws;
		logic       is_hash;
		logic       is_newline;
	} tok_t;

endpackage

`default_nettype wire

[rtl/ppmp6_in_if.sv]
// ----------------------------------------------------------------------------
// ppmp6_in_if
// Byte stream channel: valid/ready with data byte and frame start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ppmp6_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

`default_nettype wire

[rtl/ppmp6_out_if.sv]
// ----------------------------------------------------------------------------
// ppmp6_out_if
// Result channel: valid/ready with header, pixel or error fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ppmp6_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] field_a;
	logic [15:0] field_b;
	logic [15:0] field_c;
	logic [2:0]  error_code;
	logic        last;

	modport source (output valid, output kind, output field_a, output field_b,
		output field_c, output error_code, output last, input ready);
	modport sink   (input valid, input kind, input field_a, input field_b,
		input field_c, input error_code, input last, output ready);
endinterface

`default_nettype wire

[rtl/ppm_p6_stream_parser.sv]
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser
// PPM P6 header and pixel stream parser: classifier, token queue, parser.
// ----------------------------------------------------------------------------
//  channel  | role   | payload
//  src_ch   | sink   | data_byte[7:0], frame_start
//  res_ch   | source | kind[1:0], field_a/b/c[15:0], error_code[2:0], last
//
//  One word per cycle sustained while res_ch is not stalled; a result is
//  registered after its byte passes the input register and the queue write.
//  The parser updates all state once per token, so it sets the rate.
//  arst_n clears all control state; parsing restarts at the first magic byte.
//  A stalled result holds the parser; the four-entry queue absorbs the
//  input side until it fills, then src_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppm_p6_stream_parser #(
	parameter int unsigned DIM_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	ppmp6_in_if.sink     src_ch,
	ppmp6_out_if.source  res_ch
);
	import ppmp6_pkg::*;

	logic push, pop, full, empty;
	tok_t push_tok, pop_tok;

	ppmp6_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_ch   (src_ch),
		.full     (full),
		.push     (push),
		.push_tok (push_tok)
	);

	ppmp6_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.full     (full),
		.pop      (pop),
		.pop_tok  (pop_tok),
		.empty    (empty)
	);

	ppmp6_back #(
		.DIM_BITS (DIM_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.pop_tok (pop_tok),
		.pop     (pop),
		.res_ch  (res_ch)
	);

endmodule

`default_nettype wire

[rtl/ppmp6_front.sv]
// ----------------------------------------------------------------------------
// ppmp6_front
// Accepts bytes and classifies them into tokens for the parse queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppmp6_front (
	input  wire               clk,
	input  wire               arst_n,
	ppmp6_in_if.sink          src_ch,
	input  wire               full,
	output logic              push,
	output ppmp6_pkg::tok_t   push_tok
);
	import ppmp6_pkg::*;

	logic valid_s1;
	tok_t tok_s1;
	tok_t tok_c;

	always_comb begin
		tok_c.data_byte   = src_ch.data_byte;
		tok_c.frame_start = src_ch.frame_start;
		tok_c.is_digit    = (src_ch.data_byte >= CHAR_ZERO) && (src_ch.data_byte <= CHAR_NINE);
		tok_c.is_ws       = (src_ch.data_byte == CHAR_SP) ||
			((src_ch.data_byte >= CHAR_TAB) && (src_ch.data_byte <= CHAR_CR));
		tok_c.is_hash     = (src_ch.data_byte == CHAR_HASH);
		tok_c.is_newline  = (src_ch.data_byte == CHAR_NL);
	end

	assign src_ch.ready = !valid_s1 || !full;
	assign push         = valid_s1 && !full;
	assign push_tok     = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ch.ready) begin
			valid_s1 <= src_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ch.ready && src_ch.valid) begin
			tok_s1 <= tok_c;
		end
	end

endmodule

`default_nettype wire

[rtl/ppmp6_queue.sv]
// ----------------------------------------------------------------------------
// ppmp6_queue
// Short token FIFO between the classifier and the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppmp6_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  ppmp6_pkg::tok_t   push_tok,
	output logic              full,
	input  wire               pop,
	output ppmp6_pkg::tok_t   pop_tok,
	output logic              empty
);
	import ppmp6_pkg::*;

	tok_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

`default_nettype wire

[rtl/ppmp6_back.sv]
// ----------------------------------------------------------------------------
// ppmp6_back
// Header/pixel parser: consumes tokens, drives the registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppmp6_back #(
	parameter int unsigned DIM_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               empty,
	input  ppmp6_pkg::tok_t   pop_tok,
	output logic              pop,
	ppmp6_out_if.source       res_ch
);
	import ppmp6_pkg::*;

	typedef enum logic [3:0] {
		PH_MAGIC1, PH_MAGIC2, PH_GAP_W, PH_NUM_W, PH_GAP_H, PH_NUM_H,
		PH_GAP_M, PH_NUM_M, PH_PIXELS, PH_ERROR, PH_DONE
	} phase_t;

	localparam logic [PROD_BITS-1:0] DimMax = (PROD_BITS'(1) << DIM_BITS) - PROD_BITS'(1);
	localparam logic [PROD_BITS-1:0] NumMax = PROD_BITS'(NUM_LIMIT);
	localparam logic [ACC_BITS-1:0]  MaxvalMax = ACC_BITS'(MAXVAL_LIMIT);

	phase_t               phase_q, phase_n, ph;
	logic                 in_comment_q, in_comment_n, cm;
	logic [ACC_BITS-1:0]  acc_q, acc_n;
	logic [DIM_BITS-1:0]  width_q, width_n;
	logic [DIM_BITS-1:0]  height_q, height_n;
	logic [DIM_BITS-1:0]  col_q, col_n;
	logic [DIM_BITS-1:0]  row_q, row_n;
	logic [1:0]           bip_q, bip_n;
	logic [7:0]           red_q, red_n;
	logic [7:0]           green_q, green_n;

	logic                 res_valid_q;
	kind_t                res_kind_q;
	logic [15:0]          res_a_q, res_b_q, res_c_q;
	err_t                 res_err_q;
	logic                 res_last_q;

	logic                 emit;
	kind_t                e_kind;
	logic [15:0]          e_a, e_b, e_c;
	err_t                 e_err;
	logic                 e_last;

	logic                 do_gap;
	logic                 gap_cm;
	phase_t               gap_tgt;
	logic [PROD_BITS-1:0] prod;
	logic [DIM_BITS:0]    col_inc, row_inc;

	assign pop = !empty && (!res_valid_q || res_ch.ready);

	// acc*10 + digit, as shift-add
	assign prod = (PROD_BITS'(acc_q) << 3) + (PROD_BITS'(acc_q) << 1)
		+ PROD_BITS'(pop_tok.data_byte[3:0]);
	assign col_inc = {1'b0, col_q} + (DIM_BITS+1)'(1);
	assign row_inc = {1'b0, row_q} + (DIM_BITS+1)'(1);

	always_comb begin
		ph = pop_tok.frame_start ? PH_MAGIC1 : phase_q;
		cm = pop_tok.frame_start ? 1'b0 : in_comment_q;

		phase_n      = ph;
		in_comment_n = cm;
		acc_n        = acc_q;
		width_n      = width_q;
		height_n     = height_q;
		col_n        = col_q;
		row_n        = row_q;
		bip_n        = bip_q;
		red_n        = red_q;
		green_n      = green_q;

		emit   = 1'b0;
		e_kind = KIND_ERROR;
		e_a    = '0;
		e_b    = '0;
		e_c    = '0;
		e_err  = ERR_BAD_MAGIC;
		e_last = 1'b0;

		do_gap  = 1'b0;
		gap_cm  = cm;
		gap_tgt = PH_NUM_W;

		case (ph)
			PH_MAGIC1: begin
				if (pop_tok.data_byte != CHAR_P) begin
					emit  = 1'b1;
					e_err = ERR_BAD_MAGIC;
				end else begin
					phase_n = PH_MAGIC2;
				end
			end
			PH_MAGIC2: begin
				if (pop_tok.data_byte != CHAR_SIX) begin
					emit  = 1'b1;
					e_err = ERR_BAD_MAGIC;
				end else begin
					phase_n      = PH_GAP_W;
					in_comment_n = 1'b0;
				end
			end
			PH_GAP_W: begin
				do_gap  = 1'b1;
				gap_tgt = PH_NUM_W;
			end
			PH_GAP_H: begin
				do_gap  = 1'b1;
				gap_tgt = PH_NUM_H;
			end
			PH_GAP_M: begin
				do_gap  = 1'b1;
				gap_tgt = PH_NUM_M;
			end
			PH_NUM_W, PH_NUM_H: begin
				if (pop_tok.is_digit) begin
					if (prod > DimMax) begin
						emit  = 1'b1;
						e_err = ERR_BAD_NUMBER;
					end else begin
						acc_n = prod[ACC_BITS-1:0];
					end
				end else begin
					// terminator is the first byte of the next gap
					do_gap = 1'b1;
					gap_cm = 1'b0;
					if (ph == PH_NUM_W) begin
						width_n = acc_q[DIM_BITS-1:0];
						phase_n = PH_GAP_H;
						gap_tgt = PH_NUM_H;
					end else begin
						height_n = acc_q[DIM_BITS-1:0];
						phase_n  = PH_GAP_M;
						gap_tgt  = PH_NUM_M;
					end
				end
			end
			PH_NUM_M: begin
				if (pop_tok.is_digit) begin
					if (prod > NumMax) begin
						emit  = 1'b1;
						e_err = ERR_BAD_NUMBER;
					end else begin
						acc_n = prod[ACC_BITS-1:0];
					end
				end else if (acc_q == '0) begin
					emit  = 1'b1;
					e_err = ERR_MAXVAL_ZERO;
				end else if (acc_q > MaxvalMax) begin
					emit  = 1'b1;
					e_err = ERR_MAXVAL_BIG;
				end else if (!pop_tok.is_ws) begin
					emit  = 1'b1;
					e_err = ERR_NO_WS;
				end else begin
					col_n  = '0;
					row_n  = '0;
					bip_n  = '0;
					emit   = 1'b1;
					e_kind = KIND_HEADER;
					e_a    = 16'(width_q);
					e_b    = 16'(height_q);
					e_c    = acc_q;
					e_err  = ERR_BAD_MAGIC;
					if ((width_q == '0) || (height_q == '0)) begin
						e_last  = 1'b1;
						phase_n = PH_DONE;
					end else begin
						phase_n = PH_PIXELS;
					end
				end
			end
			PH_PIXELS: begin
				case (bip_q)
					2'd0: begin
						red_n = pop_tok.data_byte;
						bip_n = 2'd1;
					end
					2'd1: begin
						green_n = pop_tok.data_byte;
						bip_n   = 2'd2;
					end
					default: begin
						bip_n  = 2'd0;
						emit   = 1'b1;
						e_kind = KIND_PIXEL;
						e_a    = 16'(red_q);
						e_b    = 16'(green_q);
						e_c    = 16'(pop_tok.data_byte);
						if ((row_inc >= {1'b0, height_q}) && (col_inc >= {1'b0, width_q})) begin
							e_last  = 1'b1;
							phase_n = PH_DONE;
						end else if (col_inc >= {1'b0, width_q}) begin
							col_n = '0;
							row_n = row_inc[DIM_BITS-1:0];
						end else begin
							col_n = col_inc[DIM_BITS-1:0];
						end
					end
				endcase
			end
			default: begin
			end
		endcase

		if (do_gap) begin
			in_comment_n = gap_cm;
			if (gap_cm) begin
				if (pop_tok.is_newline) begin
					in_comment_n = 1'b0;
				end
			end else if (pop_tok.is_ws) begin
				in_comment_n = 1'b0;
			end else if (pop_tok.is_hash) begin
				in_comment_n = 1'b1;
			end else if (pop_tok.is_digit) begin
				acc_n   = ACC_BITS'(pop_tok.data_byte[3:0]);
				phase_n = gap_tgt;
			end else begin
				emit  = 1'b1;
				e_err = ERR_BAD_NUMBER;
			end
		end

		if (emit && (e_kind == KIND_ERROR)) begin
			phase_n      = PH_ERROR;
			in_comment_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MAGIC1;
			in_comment_q <= 1'b0;
			acc_q        <= '0;
			width_q      <= '0;
			height_q     <= '0;
			col_q        <= '0;
			row_q        <= '0;
			bip_q        <= '0;
			red_q        <= '0;
			green_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				phase_q      <= phase_n;
				in_comment_q <= in_comment_n;
				acc_q        <= acc_n;
				width_q      <= width_n;
				height_q     <= height_n;
				col_q        <= col_n;
				row_q        <= row_n;
				bip_q        <= bip_n;
				red_q        <= red_n;
				green_q      <= green_n;
			end
			if (!res_valid_q || res_ch.ready) begin
				res_valid_q <= pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_kind_q <= e_kind;
			res_a_q    <= e_a;
			res_b_q    <= e_b;
			res_c_q    <= e_c;
			res_err_q  <= e_err;
			res_last_q <= e_last;
		end
	end

	assign res_ch.valid      = res_valid_q;
	assign res_ch.kind       = res_kind_q;
	assign res_ch.field_a    = res_a_q;
	assign res_ch.field_b    = res_b_q;
	assign res_ch.field_c    = res_c_q;
	assign res_ch.error_code = res_err_q;
	assign res_ch.last       = res_last_q;

endmodule

`default_nettype wire
